// ===== src/nearest_palette_color_mapper_top_defines.svh =====
// assertion macros for the nearest palette color mapper
// used by the top level; expects signals named clk and rst in scope
`ifndef NEAREST_PALETTE_COLOR_MAPPER_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_TOP_DEFINES_SVH

// check that stays off while reset is high
`define NPCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define NPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/npcm_pkg.sv =====
// shared types, constants and helpers of the nearest palette color mapper
// no dependencies; imported by npcm_cell and the top level
`default_nettype none

package npcm_pkg;

  // palette size and derived widths
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

  // distance bound, above any reachable squared distance
  localparam int unsigned DIST_START_INT = 3 * 256 * 256;
  localparam int unsigned DIST_W = $clog2(DIST_START_INT + 1);
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(DIST_START_INT);

  // item kinds
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  // item as it travels down the chain of cells
  typedef struct packed {
    logic              valid;
    opcode_t           opcode;
    logic [7:0]        entry_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } item_t;

  // winning index masked to the 8-bit result field
  function automatic logic [7:0] to_color_index(input logic [IDX_W-1:0] idx);
    logic [15:0] wide;
    wide = 16'(idx);
    return wide[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/npcm_cell.sv =====
// one cell of the search chain: holds one palette entry, compares the
// passing pixel against it and forwards the running best; uses npcm_pkg
`default_nettype none

module npcm_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             advance,
  input  wire logic [npcm_pkg::IDX_W-1:0]       cell_index,
  input  wire logic [npcm_pkg::COUNT_W-1:0]     color_count,
  input  wire npcm_pkg::item_t                  up,
  output npcm_pkg::item_t                       down
);
  import npcm_pkg::*;

  logic [23:0]       entry;
  logic [7:0]        dr;
  logic [7:0]        dg;
  logic [7:0]        db;
  logic [15:0]       sr;
  logic [15:0]       sg;
  logic [15:0]       sb;
  logic [DIST_W-1:0] sq_sum;
  logic              active;
  logic              hit;
  logic              load_hit;
  item_t             down_next;

  // distance to the stored entry and update of the running best
  always_comb begin
    dr = (entry[23:16] >= up.red)   ? entry[23:16] - up.red   : up.red   - entry[23:16];
    dg = (entry[15:8]  >= up.green) ? entry[15:8]  - up.green : up.green - entry[15:8];
    db = (entry[7:0]   >= up.blue)  ? entry[7:0]   - up.blue  : up.blue  - entry[7:0];
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    sq_sum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    active = CMP_W'(cell_index) < CMP_W'(color_count);
    hit = up.valid && (up.opcode == OP_PIXEL) && active && (sq_sum < up.best_dist);
    load_hit = up.valid && (up.opcode == OP_LOAD) &&
               (CMP_W'(up.entry_index) == CMP_W'(cell_index));
    down_next = up;
    if (hit) begin
      down_next.best_dist = sq_sum;
      down_next.best_idx  = cell_index;
    end
  end

  // entry store and hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      entry      <= '0;
      down.valid <= 1'b0;
    end else if (advance) begin
      down <= down_next;
      if (load_hit) begin
        entry <= {up.red, up.green, up.blue};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/nearest_palette_color_mapper_top.sv =====
// nearest palette color mapper: how to use it
// s_axis carries items in: tuser is the kind (0 load a palette entry,
// 1 map a pixel), tdata holds entry_index, red, green and blue. a load
// writes one entry and gives no result; a pixel gives one item on m_axis
// whose tdata is the index of the nearest entry among the first
// color_count entries, lowest index on ties.
// cfg_we / cfg_wdata write color_count; write it only while idle.
// throughput is one item per cycle while m_axis does not stall: a chain
// of PALETTE_ENTRIES cells, one cell per palette entry, moves every item
// one cell each cycle; an accepted pixel passes the whole chain and then
// the output register before its result reaches m_axis.
// loads travel down the chain in order with pixels, so a pixel always
// sees the palette as written by the items accepted before it.
// reset clears every palette entry to zero at once and sets color_count
// to 256; there is no clearing pass, items are accepted right after.
// when m_axis stalls with a result waiting, the whole chain holds and
// s_axis_tready drops until the result is taken.
`default_nettype none
`include "nearest_palette_color_mapper_top_defines.svh"

module nearest_palette_color_mapper_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // config: color_count
  input  wire logic                         cfg_we,
  input  wire logic [npcm_pkg::COUNT_W-1:0] cfg_wdata,
  // tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  wire logic [31:0]                  s_axis_tdata,
  // tuser: opcode[0]
  input  wire logic [0:0]                   s_axis_tuser,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: color_index[7:0]
  output logic [7:0]                        m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready
);
  import npcm_pkg::*;

  logic [COUNT_W-1:0] color_count_q;
  logic               advance;
  item_t              chain [0:PALETTE_ENTRIES];
  item_t              tail;

  // color count register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_count_q <= COUNT_RESET;
    end else if (cfg_we) begin
      color_count_q <= cfg_wdata;
    end
  end

  // whole chain moves when the output slot is free or being drained
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // item entering the first cell
  always_comb begin
    chain[0].valid       = s_axis_tvalid;
    chain[0].opcode      = opcode_t'(s_axis_tuser[0]);
    chain[0].entry_index = s_axis_tdata[7:0];
    chain[0].red         = s_axis_tdata[15:8];
    chain[0].green       = s_axis_tdata[23:16];
    chain[0].blue        = s_axis_tdata[31:24];
    chain[0].best_dist   = DIST_START;
    chain[0].best_idx    = '0;
  end

  // row of cells, one per palette entry
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    npcm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .cell_index  (IDX_W'(k)),
      .color_count (color_count_q),
      .up          (chain[k]),
      .down        (chain[k+1])
    );
  end

  assign tail = chain[PALETTE_ENTRIES];

  // output register; loads leave the chain without a result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= tail.valid && (tail.opcode == OP_PIXEL);
      m_axis_tdata  <= to_color_index(tail.best_idx);
    end
  end

  // checks
  `NPCM_ASSERT_RST(a_stall_blocks_input, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input accepted while result stalled")
  `NPCM_ASSERT_RST(a_pixel_gives_result, (advance && tail.valid && (tail.opcode == OP_PIXEL)) |=> m_axis_tvalid, "pixel leaving chain gave no result")
  `NPCM_ASSERT_RST(a_load_no_result, (advance && !(tail.valid && (tail.opcode == OP_PIXEL))) |=> !m_axis_tvalid, "result without a pixel")
  `NPCM_ASSERT(a_count_reset, rst |=> (color_count_q == COUNT_RESET), "color count not reset")

endmodule

`default_nettype wire
